// ----- hw/rtl/hqt_pkg.sv -----
// Shared types and constants for the heightmap triangle height query block.
package hqt_pkg;

   // Field widths fixed by the block's interface
   localparam int unsigned SAMPLE_W = 8;
   localparam int unsigned INDEX_W = 9;
   localparam int unsigned POS_W = 18;
   localparam int unsigned HEIGHT_W = 16;
   localparam int HEIGHT_MAX = 65535;

   // Upper bounds over the supported grid and fraction range
   localparam int unsigned WGT_MAX_W = 16;
   localparam int unsigned ADDR_MAX_W = 19;

   // Four parity banks: bit 0 is column parity, bit 1 is row parity
   localparam int unsigned BANKS = 4;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [INDEX_W-1:0] TILE_COUNT_RESET = 9'd256;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   // One classified request as it travels from front to back
   typedef struct packed {
      logic                                 is_write;
      logic                                 on_land;
      logic                                 upper;
      logic                                 x_odd;
      logic                                 z_odd;
      logic [WGT_MAX_W-1:0]                 wgt_a;
      logic [WGT_MAX_W-1:0]                 wgt_b;
      logic [BANKS-1:0]                     bank_en;
      logic [SAMPLE_W-1:0]                  data;
      logic [BANKS-1:0][ADDR_MAX_W-1:0]     addr;
   } hqt_entry_type;

endpackage

// ----- hw/rtl/hqt_front.sv -----
// Front end: accepts requests, holds the tile count, classifies and addresses each request.
module hqt_front #(
   parameter int unsigned GRID_MAX = 256,
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [hqt_pkg::SAMPLE_W-1:0]      req_height_sample,
   input  logic [hqt_pkg::INDEX_W-1:0]       req_grid_col,
   input  logic [hqt_pkg::INDEX_W-1:0]       req_grid_row,
   input  logic signed [hqt_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [hqt_pkg::POS_W-1:0]  req_pos_z,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hqt_pkg::INDEX_W-1:0]       csr_data,
   input  logic                              queue_full,
   output logic                              push,
   output hqt_pkg::hqt_entry_type            push_entry
);
   import hqt_pkg::*;

   localparam int unsigned IW = $clog2(GRID_MAX + 1);
   localparam int unsigned HALF = GRID_MAX / 2 + 1;
   localparam int unsigned HW = $clog2(HALF);
   localparam int unsigned AW = $clog2(HALF * HALF);
   localparam int unsigned XW = POS_W - 1 - FRAC_BITS;

   logic [INDEX_W-1:0]   tile_count_ff;
   logic [INDEX_W-1:0]   tile_count_in;
   logic [INDEX_W-1:0]   tile_eff;
   logic [XW-1:0]        cell_x;
   logic [XW-1:0]        cell_z;
   logic [FRAC_BITS-1:0] frac_x;
   logic [FRAC_BITS-1:0] frac_z;
   logic [FRAC_BITS-1:0] comp_x;
   logic [FRAC_BITS-1:0] comp_z;
   logic [FRAC_BITS:0]   frac_sum;
   logic                 upper;
   logic                 off_grid;
   logic [IW-1:0]        ix;
   logic [IW-1:0]        iz;
   logic                 wr_ok;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        q_addr [BANKS];

   // Accept a request whenever the queue has room and reset is released
   assign busy = reset | queue_full;
   assign push = start & ~busy;
   assign csr_ready = ~reset;

   // Hold the tile count register
   assign tile_count_in = (csr_valid && csr_ready) ? csr_data : tile_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_count_ff <= TILE_COUNT_RESET;
      end else begin
         tile_count_ff <= tile_count_in;
      end
   end

   // Classify the query position against the grid in use
   assign tile_eff = (32'(tile_count_ff) > 32'(GRID_MAX)) ? INDEX_W'(GRID_MAX)
                                                          : tile_count_ff;
   assign cell_x = req_pos_x[POS_W-2:FRAC_BITS];
   assign cell_z = req_pos_z[POS_W-2:FRAC_BITS];
   assign frac_x = req_pos_x[FRAC_BITS-1:0];
   assign frac_z = req_pos_z[FRAC_BITS-1:0];
   assign comp_x = ~frac_x + FRAC_BITS'(1);
   assign comp_z = ~frac_z + FRAC_BITS'(1);
   assign frac_sum = {1'b0, frac_x} + {1'b0, frac_z};
   assign upper = frac_sum[FRAC_BITS];

   assign off_grid = req_pos_x[POS_W-1] || req_pos_z[POS_W-1]
                     || (32'(cell_x) >= 32'(tile_eff))
                     || (32'(cell_z) >= 32'(tile_eff));

   // Park the cell at the origin when off grid so bank reads stay in range
   assign ix = off_grid ? '0 : IW'(32'(cell_x));
   assign iz = off_grid ? '0 : IW'(32'(cell_z));

   // Address each parity bank for the four cell corners
   always_comb begin
      logic [IW:0] col_sum;
      logic [IW:0] row_sum;
      col_sum = '0;
      row_sum = '0;
      for (int b = 0; b < BANKS; b++) begin
         col_sum = {1'b0, ix} + (IW+1)'(b[0] ^ ix[0]);
         row_sum = {1'b0, iz} + (IW+1)'(b[1] ^ iz[0]);
         q_addr[b] = AW'(32'(row_sum[HW:1]) * HALF + 32'(col_sum[HW:1]));
      end
   end

   // Address the single bank that a sample write lands in
   assign wr_ok = (32'(req_grid_col) <= 32'(GRID_MAX)) && (32'(req_grid_row) <= 32'(GRID_MAX));
   assign wr_addr = AW'(32'(req_grid_row[INDEX_W-1:1]) * HALF
                        + 32'(req_grid_col[INDEX_W-1:1]));

   // Build the queue entry
   always_comb begin
      push_entry = '0;
      push_entry.is_write = (req_action == ACT_WRITE);
      push_entry.on_land = ~off_grid;
      push_entry.upper = upper;
      push_entry.x_odd = ix[0];
      push_entry.z_odd = iz[0];
      push_entry.wgt_a = WGT_MAX_W'(upper ? comp_x : frac_z);
      push_entry.wgt_b = WGT_MAX_W'(upper ? comp_z : frac_x);
      push_entry.data = req_height_sample;
      for (int b = 0; b < BANKS; b++) begin
         push_entry.bank_en[b] = wr_ok && (2'(b) == {req_grid_row[0], req_grid_col[0]});
         push_entry.addr[b] = ADDR_MAX_W'(push_entry.is_write ? wr_addr : q_addr[b]);
      end
   end

endmodule

// ----- hw/rtl/hqt_queue.sv -----
// Short request queue between the front end and the back end.
module hqt_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hqt_pkg::hqt_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output hqt_pkg::hqt_entry_type pop_entry,
   output logic                   empty
);
   import hqt_pkg::*;

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   hqt_entry_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff;
   logic [PW-1:0] rd_ptr_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          do_push;
   logic          do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop = pop & ~empty;
   assign pop_entry = entries_ff[rd_ptr_ff];

   // Advance the pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store the incoming request
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/hqt_back.sv -----
// Back end: parity-banked sample store, corner fetch, interpolation and result register.
module hqt_back #(
   parameter int unsigned GRID_MAX = 256,
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          empty,
   input  hqt_pkg::hqt_entry_type        pop_entry,
   output logic                          pop,
   output logic                          rsp_strobe,
   output logic                          rsp_on_land,
   output logic [hqt_pkg::HEIGHT_W-1:0]  rsp_height_value
);
   import hqt_pkg::*;

   localparam int unsigned HALF = GRID_MAX / 2 + 1;
   localparam int unsigned MEM_DEPTH = HALF * HALF;
   localparam int unsigned AW = $clog2(MEM_DEPTH);
   localparam int unsigned PRODW = FRAC_BITS + 10;
   localparam int unsigned SW = FRAC_BITS + 13;

   // Fetch stage
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s1_on_land_ff;
   logic                 s1_upper_ff;
   logic                 s1_x_odd_ff;
   logic                 s1_z_odd_ff;
   logic [FRAC_BITS-1:0] s1_wgt_a_ff;
   logic [FRAC_BITS-1:0] s1_wgt_b_ff;
   logic [SAMPLE_W-1:0]  rd_data_ff [BANKS];

   // Multiply stage
   logic                    s2_valid_ff;
   logic                    s2_on_land_ff;
   logic [SAMPLE_W-1:0]     s2_base_ff;
   logic [SAMPLE_W-1:0]     s2_base_in;
   logic signed [PRODW-1:0] s2_prod_a_ff;
   logic signed [PRODW-1:0] s2_prod_a_in;
   logic signed [PRODW-1:0] s2_prod_b_ff;
   logic signed [PRODW-1:0] s2_prod_b_in;

   // Result register
   logic                rsp_strobe_ff;
   logic                rsp_on_land_ff;
   logic [HEIGHT_W-1:0] rsp_height_ff;
   logic [HEIGHT_W-1:0] rsp_height_in;

   logic [SAMPLE_W-1:0] even_c0;
   logic [SAMPLE_W-1:0] even_c1;
   logic [SAMPLE_W-1:0] odd_c0;
   logic [SAMPLE_W-1:0] odd_c1;
   logic [SAMPLE_W-1:0] h00;
   logic [SAMPLE_W-1:0] h01;
   logic [SAMPLE_W-1:0] h10;
   logic [SAMPLE_W-1:0] h11;
   logic signed [SAMPLE_W:0] diff_a;
   logic signed [SAMPLE_W:0] diff_b;
   logic signed [SW-1:0] base_ext;
   logic signed [SW-1:0] sum;
   int                   sum_int;

   // Drain the queue every cycle: the result side never stalls
   assign pop = ~empty;
   assign s1_valid_in = pop && !pop_entry.is_write;

   // Write or read each parity bank, one access per bank per cycle
   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      logic [SAMPLE_W-1:0] bank_mem [MEM_DEPTH];
      logic [AW-1:0]       bank_addr;

      assign bank_addr = pop_entry.addr[b][AW-1:0];

      always_ff @(posedge clock) begin
         if (pop && pop_entry.is_write && pop_entry.bank_en[b]) begin
            bank_mem[bank_addr] <= pop_entry.data;
         end
         if (s1_valid_in) begin
            rd_data_ff[b] <= bank_mem[bank_addr];
         end
      end
   end

   // Carry the query control alongside the bank reads
   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_on_land_ff <= pop_entry.on_land;
         s1_upper_ff <= pop_entry.upper;
         s1_x_odd_ff <= pop_entry.x_odd;
         s1_z_odd_ff <= pop_entry.z_odd;
         s1_wgt_a_ff <= pop_entry.wgt_a[FRAC_BITS-1:0];
         s1_wgt_b_ff <= pop_entry.wgt_b[FRAC_BITS-1:0];
      end
   end

   // Unscramble the banks into the four corners of the cell
   assign even_c0 = s1_x_odd_ff ? rd_data_ff[1] : rd_data_ff[0];
   assign even_c1 = s1_x_odd_ff ? rd_data_ff[0] : rd_data_ff[1];
   assign odd_c0 = s1_x_odd_ff ? rd_data_ff[3] : rd_data_ff[2];
   assign odd_c1 = s1_x_odd_ff ? rd_data_ff[2] : rd_data_ff[3];
   assign h00 = s1_z_odd_ff ? odd_c0 : even_c0;
   assign h10 = s1_z_odd_ff ? odd_c1 : even_c1;
   assign h01 = s1_z_odd_ff ? even_c0 : odd_c0;
   assign h11 = s1_z_odd_ff ? even_c1 : odd_c1;

   // Take edge differences from the triangle's base corner and weight them
   always_comb begin
      s2_base_in = s1_upper_ff ? h11 : h00;
      diff_a = $signed({1'b0, h01}) - $signed({1'b0, s2_base_in});
      diff_b = $signed({1'b0, h10}) - $signed({1'b0, s2_base_in});
      s2_prod_a_in = diff_a * $signed({1'b0, s1_wgt_a_ff});
      s2_prod_b_in = diff_b * $signed({1'b0, s1_wgt_b_ff});
   end

   always_ff @(posedge clock) begin
      s2_base_ff <= s2_base_in;
      s2_prod_a_ff <= s2_prod_a_in;
      s2_prod_b_ff <= s2_prod_b_in;
      s2_on_land_ff <= s1_on_land_ff;
   end

   // Sum, saturate and force zero off grid
   always_comb begin
      base_ext = SW'($signed({1'b0, s2_base_ff})) <<< FRAC_BITS;
      sum = base_ext + SW'(s2_prod_a_ff) + SW'(s2_prod_b_ff);
      sum_int = int'(sum);
      priority if (!s2_on_land_ff || sum_int < 0) begin
         rsp_height_in = '0;
      end else if (sum_int > HEIGHT_MAX) begin
         rsp_height_in = HEIGHT_W'(HEIGHT_MAX);
      end else begin
         rsp_height_in = HEIGHT_W'(sum_int);
      end
   end

   always_ff @(posedge clock) begin
      rsp_on_land_ff <= s2_on_land_ff;
      rsp_height_ff <= rsp_height_in;
   end

   // Advance the stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         rsp_strobe_ff <= s2_valid_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_on_land = rsp_on_land_ff;
   assign rsp_height_value = rsp_height_ff;

endmodule

// ----- hw/rtl/heightmap_triangle_height_query.sv -----
// Heightmap triangle height query: top level joining front end, queue and back end.
//
// Request channel: a request is taken at a rising edge with start high and busy
// low. action 0 writes height_sample at (grid_col, grid_row); action 1 queries
// the interpolated height at (pos_x, pos_z), 8 fraction bits by default.
// Response channel: one response per query, none per write. rsp_strobe marks
// rsp_on_land and rsp_height_value for exactly one cycle; the receiver cannot
// stall, so every response is taken at the edge that ends that cycle.
// Path: queue, bank read, multiply, then the sum and saturate result register.
// Throughput: one request per cycle, set by the four parity-banked sample
// memories, each with one port, so that a query reads its four corners at once.
// Requests leave in order, so a query sees every write accepted before it.
// Configuration: csr_data is the tile count, written at an edge with csr_valid
// and csr_ready high. The user must write it only while no request is in
// flight; the block itself does not enforce this rule.
// Reset: synchronous, clears the queue and pipeline and sets the tile count to
// 256; busy is held high and csr_ready low during reset. The sample store has
// no reset and must be written before it is queried.
module heightmap_triangle_height_query #(
   parameter int unsigned GRID_MAX = 256,
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [hqt_pkg::SAMPLE_W-1:0]      req_height_sample,
   input  logic [hqt_pkg::INDEX_W-1:0]       req_grid_col,
   input  logic [hqt_pkg::INDEX_W-1:0]       req_grid_row,
   input  logic signed [hqt_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [hqt_pkg::POS_W-1:0]  req_pos_z,
   output logic                              rsp_strobe,
   output logic                              rsp_on_land,
   output logic [hqt_pkg::HEIGHT_W-1:0]      rsp_height_value,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hqt_pkg::INDEX_W-1:0]       csr_data
);
   import hqt_pkg::*;

   hqt_entry_type push_entry;
   hqt_entry_type pop_entry;
   logic          push;
   logic          pop;
   logic          queue_full;
   logic          queue_empty;

   // Accept and classify requests
   hqt_front #(
      .GRID_MAX (GRID_MAX),
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_height_sample(req_height_sample),
      .req_grid_col     (req_grid_col),
      .req_grid_row     (req_grid_row),
      .req_pos_x        (req_pos_x),
      .req_pos_z        (req_pos_z),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   // Decouple the two halves
   hqt_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (queue_full),
      .pop       (pop),
      .pop_entry (pop_entry),
      .empty     (queue_empty)
   );

   // Store samples and interpolate queries
   hqt_back #(
      .GRID_MAX (GRID_MAX),
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (queue_empty),
      .pop_entry       (pop_entry),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_on_land     (rsp_on_land),
      .rsp_height_value(rsp_height_value)
   );

endmodule

// ----- hw/rtl/hqt_checker.sv -----
// Port-level checks for the heightmap triangle height query block, with its bind.
module hqt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              req_action,
   input logic signed [hqt_pkg::POS_W-1:0]  req_pos_x,
   input logic                              rsp_strobe,
   input logic                              rsp_on_land,
   input logic [hqt_pkg::HEIGHT_W-1:0]      rsp_height_value
);
   import hqt_pkg::*;

   // Drop every response in flight on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("response strobe after reset");

   // An off-grid response carries zero height
   a_off_grid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_on_land) |-> (rsp_height_value == '0))
      else $error("off-grid response with non-zero height");

   // Every query request gives a response at fixed latency
   a_query_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_QUERY) |-> ##4 rsp_strobe)
      else $error("query request without response");

   // A write request gives no response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_WRITE) |-> ##4 !rsp_strobe)
      else $error("write request produced a response");

   // A negative X position is always off grid
   a_neg_x_off: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_QUERY && req_pos_x[POS_W-1])
      |-> ##4 (rsp_strobe && !rsp_on_land))
      else $error("negative position reported on land");

endmodule

bind heightmap_triangle_height_query hqt_checker u_hqt_checker (.*);

// ----- tb/tb_heightmap_triangle_height_query.sv -----
// Self-checking testbench for the heightmap triangle height query block.
module tb_heightmap_triangle_height_query;
   timeunit 1ns;
   timeprecision 1ps;

   import hqt_pkg::*;

   localparam int GRID_MAX     = 256;
   localparam int FRAC_BITS    = 8;
   localparam int ONE          = 1 << FRAC_BITS;
   localparam int PITCH        = GRID_MAX + 1;
   localparam int LATENCY      = 3;
   localparam int DRAIN_CYCLES = LATENCY + 3;
   localparam int STALL_LIMIT  = 2000;
   localparam int BLOCK_ITEMS  = 120;
   localparam int N_DIRECTED   = 24;

   typedef struct {
      logic                on_land;
      logic [HEIGHT_W-1:0] height;
   } reply_type;

   typedef struct {
      action_type                act;
      logic [SAMPLE_W-1:0]       sample;
      logic [INDEX_W-1:0]        col;
      logic [INDEX_W-1:0]        row;
      logic signed [POS_W-1:0]   px;
      logic signed [POS_W-1:0]   pz;
      bit                        fixed;
      reply_type                 reply;
   } directed_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic                        req_action = 1'b0;
   logic [SAMPLE_W-1:0]         req_height_sample = '0;
   logic [INDEX_W-1:0]          req_grid_col = '0;
   logic [INDEX_W-1:0]          req_grid_row = '0;
   logic signed [POS_W-1:0]     req_pos_x = '0;
   logic signed [POS_W-1:0]     req_pos_z = '0;
   logic                        rsp_strobe;
   logic                        rsp_on_land;
   logic [HEIGHT_W-1:0]         rsp_height_value;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [INDEX_W-1:0]          csr_data = '0;

   // Mirror of the sample store and the tile count register
   logic [SAMPLE_W-1:0] sample_mirror [0:PITCH*PITCH-1];
   bit                  sample_known  [0:PITCH*PITCH-1];
   int                  tile_count;

   reply_type pending_replies [$];
   directed_row_type directed_rows [0:N_DIRECTED-1];

   int sender_idle_pct = 0;
   int block_items;
   int n_errors = 0;
   int n_writes = 0;
   int n_ignored = 0;
   int n_queries = 0;
   int n_on_land = 0;
   int n_settings = 0;
   int stall_cycles = 0;

   heightmap_triangle_height_query u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_height_sample(req_height_sample),
      .req_grid_col     (req_grid_col),
      .req_grid_row     (req_grid_row),
      .req_pos_x        (req_pos_x),
      .req_pos_z        (req_pos_z),
      .rsp_strobe       (rsp_strobe),
      .rsp_on_land      (rsp_on_land),
      .rsp_height_value (rsp_height_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int effective_tiles();
      return (tile_count > GRID_MAX) ? GRID_MAX : tile_count;
   endfunction

   function automatic int stored(input int col, input int row);
      return int'(sample_mirror[row*PITCH + col]);
   endfunction

   // Interpolate over the triangle of the cell that the position falls in
   function automatic reply_type interpolate_height(input logic signed [POS_W-1:0] px,
                                                    input logic signed [POS_W-1:0] pz);
      reply_type r;
      int tc, x, z, fx, fz, h, corner, gx, gz;
      tc = effective_tiles();
      r.on_land = 1'b0;
      r.height  = '0;
      if (px < 0 || pz < 0 || px >= tc*ONE || pz >= tc*ONE) return r;
      x  = int'(px) / ONE;
      z  = int'(pz) / ONE;
      fx = int'(px) % ONE;
      fz = int'(pz) % ONE;
      if (fx + fz < ONE) begin
         corner = stored(x, z);
         h = corner*ONE + (stored(x, z+1) - corner)*fz + (stored(x+1, z) - corner)*fx;
      end else begin
         corner = stored(x+1, z+1);
         gx = ONE - fx;
         gz = ONE - fz;
         h = corner*ONE + (stored(x, z+1) - corner)*gx + (stored(x+1, z) - corner)*gz;
      end
      if (h < 0) h = 0;
      if (h > HEIGHT_MAX) h = HEIGHT_MAX;
      r.on_land = 1'b1;
      r.height  = h[HEIGHT_W-1:0];
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_height();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return SAMPLE_W'($urandom_range(255));
   endfunction

   // Cells near the origin and the far edge are favoured so samples get reused
   function automatic int pick_cell(input int tc);
      int r;
      r = $urandom_range(99);
      if (r < 50) return $urandom_range(0, (tc-1 < 5) ? tc-1 : 5);
      if (r < 70) return tc - 1 - $urandom_range(0, (tc-1 < 3) ? tc-1 : 3);
      return $urandom_range(0, tc-1);
   endfunction

   function automatic int pick_frac();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 0;
      if (r < 20) return ONE - 1;
      return $urandom_range(0, ONE-1);
   endfunction

   // A coordinate that lies off the grid on its axis, or anything at all
   function automatic logic signed [POS_W-1:0] off_axis(input int tc);
      logic [POS_W-1:0] raw;
      raw = POS_W'($urandom);
      unique case ($urandom_range(3))
         0: return POS_W'(-int'($urandom_range(1, 131072)));
         1: return POS_W'(tc*ONE + int'($urandom_range(0, 131071 - tc*ONE)));
         2: return POS_W'(tc*ONE);
         default: return raw;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
      n_errors++;
   endtask

   // Present one request, hold it until taken, then record its effect
   task automatic issue_request(input action_type act, input logic [SAMPLE_W-1:0] sample,
                                input logic [INDEX_W-1:0] col, input logic [INDEX_W-1:0] row,
                                input logic signed [POS_W-1:0] px,
                                input logic signed [POS_W-1:0] pz,
                                input bit fixed, input reply_type fixed_reply);
      int addr;
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start             <= 1'b1;
      req_action        <= act;
      req_height_sample <= sample;
      req_grid_col      <= col;
      req_grid_row      <= row;
      req_pos_x         <= px;
      req_pos_z         <= pz;
      do @(posedge clock); while (busy);
      if (act == ACT_WRITE) begin
         if (col <= GRID_MAX && row <= GRID_MAX) begin
            addr = int'(row)*PITCH + int'(col);
            sample_mirror[addr] = sample;
            sample_known[addr]  = 1'b1;
            n_writes++;
            block_items++;
         end else begin
            n_ignored++;
         end
      end else begin
         pending_replies.insert(pending_replies.size(),
                                fixed ? fixed_reply : interpolate_height(px, pz));
         n_queries++;
         block_items++;
      end
   endtask

   // Drain the pipeline, then write the tile count
   task automatic write_tile_count(input logic [INDEX_W-1:0] value);
      @(negedge clock);
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      tile_count = int'(value);
      n_settings++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One tile count setting followed by a mix of writes and queries
   task automatic run_block(input int tc_value);
      int tc, cx, cz, fx, fz, addr;
      logic signed [POS_W-1:0] px, pz;
      logic [INDEX_W-1:0] col, row;
      write_tile_count(tc_value[INDEX_W-1:0]);
      tc = effective_tiles();
      block_items = 0;
      while (block_items < BLOCK_ITEMS) begin
         if ($urandom_range(99) < 30) begin
            // Scattered write, mostly inside the grid in use
            col = ($urandom_range(99) < 85)
                  ? INDEX_W'($urandom_range(0, (tc == 0) ? GRID_MAX : tc))
                  : INDEX_W'($urandom);
            row = ($urandom_range(99) < 85)
                  ? INDEX_W'($urandom_range(0, (tc == 0) ? GRID_MAX : tc))
                  : INDEX_W'($urandom);
            issue_request(ACT_WRITE, random_height(), col, row,
                          POS_W'($urandom), POS_W'($urandom), 1'b0, '{1'b0, '0});
         end else begin
            if (tc > 0 && $urandom_range(99) < 80) begin
               cx = pick_cell(tc);
               cz = pick_cell(tc);
               fx = pick_frac();
               fz = pick_frac();
               // Land on or beside the split line now and then
               if ($urandom_range(9) == 0) begin
                  fz = ONE - 1 - fx + $urandom_range(0, 1);
                  if (fz > ONE - 1) fz = ONE - 1;
               end
               px = POS_W'(cx*ONE + fx);
               pz = POS_W'(cz*ONE + fz);
            end else begin
               px = off_axis(tc);
               pz = ($urandom_range(1) == 0) ? off_axis(tc) : POS_W'($urandom);
               if ($urandom_range(1) == 0) {px, pz} = {pz, px};
            end
            // Fill any unwritten corner of the cell before querying it
            if (px >= 0 && pz >= 0 && px < tc*ONE && pz < tc*ONE) begin
               cx = int'(px) / ONE;
               cz = int'(pz) / ONE;
               for (int dz = 0; dz < 2; dz++) begin
                  for (int dx = 0; dx < 2; dx++) begin
                     addr = (cz+dz)*PITCH + cx + dx;
                     if (!sample_known[addr])
                        issue_request(ACT_WRITE, random_height(), INDEX_W'(cx+dx),
                                      INDEX_W'(cz+dz), POS_W'($urandom), POS_W'($urandom),
                                      1'b0, '{1'b0, '0});
                  end
               end
            end
            issue_request(ACT_QUERY, SAMPLE_W'($urandom), INDEX_W'($urandom),
                          INDEX_W'($urandom), px, pz, 1'b0, '{1'b0, '0});
         end
      end
   endtask

   // Check each reply against the oldest expectation
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("reply with no query waiting, height", 32'(rsp_height_value), 0);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_on_land !== want.on_land)
               report_mismatch("on_land", 32'(rsp_on_land), 32'(want.on_land));
            if (rsp_height_value !== want.height)
               report_mismatch("height_value", 32'(rsp_height_value), 32'(want.height));
            if (want.on_land) n_on_land++;
         end
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles at %0t", STALL_LIMIT, $time);
            $display("[heightmap_triangle_height_query] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int tc_plan [0:8];
      int idle_plan [0:2];

      // Cell (0,0) ramps from 0 to 255 along each axis; -1 and -131072 are raw patterns
      directed_rows = '{
         '{ACT_WRITE, 8'd0,   9'd0,   9'd0,   18'sd0,      18'sd0,      1'b0, '{1'b0, 16'd0}},
         '{ACT_WRITE, 8'd255, 9'd1,   9'd0,   18'sd0,      18'sd0,      1'b0, '{1'b0, 16'd0}},
         '{ACT_WRITE, 8'd255, 9'd0,   9'd1,   18'sd0,      18'sd0,      1'b0, '{1'b0, 16'd0}},
         '{ACT_WRITE, 8'd0,   9'd1,   9'd1,   18'sd0,      18'sd0,      1'b0, '{1'b0, 16'd0}},
         '{ACT_QUERY, 8'd0,   9'd0,   9'd0,   18'sd0,      18'sd0,      1'b1, '{1'b1, 16'd0}},
         '{ACT_QUERY, 8'd0,   9'd0,   9'd0,   18'sd255,    18'sd0,      1'b0, '{1'b0, 16'd0}},
         '{ACT_QUERY, 8'd0,   9'd0,   9'd0,   18'sd0,      18'sd255,    1'b0, '{1'b0, 16'd0}},
         '{ACT_QUERY, 8'd0,   9'd0,   9'd0,   18'sd128,    18'sd128,    1'b0, '{1'b0, 16'd0}},
         '{ACT_QUERY, 8'd0,   9'd0,   9'd0,   18'sd255,    18'sd255,    1'b0, '{1'b0, 16'd0}},
         '{ACT_QUERY, 8'd0,   9'd0,   9'd0,   18'sh3FFFF,  18'sd0,      1'b1, '{1'b0, 16'd0}},
         '{ACT_QUERY, 8'd0,   9'd0,   9'd0,   18'sd0,      18'sh20000,  1'b1, '{1'b0, 16'd0}},
         '{ACT_QUERY, 8'd0,   9'd0,   9'd0,   18'sd131071, 18'sd131071, 1'b1, '{1'b0, 16'd0}},
         '{ACT_QUERY, 8'd0,   9'd0,   9'd0,   18'sd65536,  18'sd0,      1'b1, '{1'b0, 16'd0}},
         '{ACT_WRITE, 8'd255, 9'd0,   9'd2,   18'sd0,      18'sd0,      1'b0, '{1'b0, 16'd0}},
         '{ACT_WRITE, 8'd255, 9'd1,   9'd2,   18'sd0,      18'sd0,      1'b0, '{1'b0, 16'd0}},
         // Out-of-range writes, one of them aliasing sample (0,1) under a flat pitch
         '{ACT_WRITE, 8'd99,  9'd257, 9'd0,   18'sd0,      18'sd0,      1'b0, '{1'b0, 16'd0}},
         '{ACT_WRITE, 8'd1,   9'd511, 9'd511, 18'sd0,      18'sd0,      1'b0, '{1'b0, 16'd0}},
         '{ACT_WRITE, 8'd1,   9'd0,   9'd257, 18'sd0,      18'sd0,      1'b0, '{1'b0, 16'd0}},
         '{ACT_QUERY, 8'd0,   9'd0,   9'd0,   18'sd0,      18'sd256,    1'b1, '{1'b1, 16'd65280}},
         '{ACT_WRITE, 8'd255, 9'd255, 9'd255, 18'sd0,      18'sd0,      1'b0, '{1'b0, 16'd0}},
         '{ACT_WRITE, 8'd255, 9'd256, 9'd255, 18'sd0,      18'sd0,      1'b0, '{1'b0, 16'd0}},
         '{ACT_WRITE, 8'd255, 9'd255, 9'd256, 18'sd0,      18'sd0,      1'b0, '{1'b0, 16'd0}},
         '{ACT_WRITE, 8'd255, 9'd256, 9'd256, 18'sd0,      18'sd0,      1'b0, '{1'b0, 16'd0}},
         '{ACT_QUERY, 8'd0,   9'd0,   9'd0,   18'sd65535,  18'sd65535,  1'b1, '{1'b1, 16'd65280}}
      };
      tc_plan   = '{256, 1, 0, 511, 257, 2, 0, 255, 0};
      tc_plan[6] = $urandom_range(3, 254);
      tc_plan[8] = $urandom_range(3, 254);
      idle_plan = '{14, 87, 0};
      tile_count = int'(TILE_COUNT_RESET);

      // Hold reset, then release it
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset tile count
      sender_idle_pct = 14;
      foreach (directed_rows[i])
         issue_request(directed_rows[i].act, directed_rows[i].sample,
                       directed_rows[i].col, directed_rows[i].row,
                       directed_rows[i].px, directed_rows[i].pz,
                       directed_rows[i].fixed, directed_rows[i].reply);

      // Random part: three sender idling profiles, three tile counts each
      for (int p = 0; p < 3; p++) begin
         sender_idle_pct = idle_plan[p];
         for (int b = 0; b < 3; b++)
            run_block(tc_plan[p*3 + b]);
      end

      // Drain and let any stray reply show up
      @(negedge clock);
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (2*DRAIN_CYCLES) @(posedge clock);
      if (pending_replies.size() != 0)
         report_mismatch("queries left without reply", pending_replies.size(), 0);

      $display("covered %0d sample writes (%0d out of range) and %0d queries, %0d on land",
               n_writes, n_ignored, n_queries, n_on_land);
      $display("across %0d tile count settings including 0, 1, 256 and above 256",
               n_settings);
      if (n_errors == 0) begin
         $display("[heightmap_triangle_height_query] OK");
      end else begin
         $display("[heightmap_triangle_height_query] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/hqt_pkg.sv
hw/rtl/hqt_front.sv
hw/rtl/hqt_queue.sv
hw/rtl/hqt_back.sv
hw/rtl/heightmap_triangle_height_query.sv
hw/rtl/hqt_checker.sv
tb/tb_heightmap_triangle_height_query.sv
